// ===== rtl/core/world_to_screen_projection_macros.svh =====
// assertion helpers for the projection block
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

// implication checked on every clock edge outside reset
`define W2S_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked on the next clock edge
`define W2S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/w2s_pkg.sv =====
package w2s_pkg;

    localparam int DATA_W      = 32;
    localparam int DIM_W       = 14;
    localparam int FRAC_BITS_D = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd1080;

    // datapath operation selects
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MAC,
        OP_CLIP,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_SCALE,
        OP_FINISH
    } w2s_op_t;

    typedef struct packed {
        w2s_op_t    op;
        logic [1:0] row;   // 0 x, 1 y, 2 w
        logic [1:0] term;  // 0..2 products, 3 translation
        logic       axis;  // 0 x, 1 y
    } w2s_cmd_t;

    typedef struct packed {
        logic div_done;
        logic visible;
    } w2s_status_t;

endpackage

// ===== rtl/core/w2s_datapath.sv =====
module w2s_datapath #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_D
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  w2s_pkg::w2s_cmd_t         cmd,
    output w2s_pkg::w2s_status_t      status,
    input  logic [3:0]                load_index,
    input  logic signed [31:0]        load_value,
    input  logic signed [31:0]        in_x,
    input  logic signed [31:0]        in_y,
    input  logic signed [31:0]        in_z,
    input  logic [w2s_pkg::DIM_W-1:0] half_w,
    input  logic [w2s_pkg::DIM_W-1:0] half_h,
    output logic                      res_visible,
    output logic signed [31:0]        res_x,
    output logic signed [31:0]        res_y
);
    import w2s_pkg::*;

    localparam int QW = 32 + FRAC_BITS + 1;        // dividend magnitude width
    localparam int NDC_W = QW + 1;
    localparam int ACC_W = 64 - FRAC_BITS + 2;     // three shifted products plus translation
    localparam logic signed [33:0] THRESH = 34'((2**FRAC_BITS + 5) / 10);
    localparam int CNT_W = $clog2(QW + 1);
    localparam int PROD_W = DIM_W + NDC_W + 1;

    logic signed [31:0] mat_reg [16];
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0] cx_reg, cy_reg, cw_reg;
    logic signed [63:0] prod_reg;
    logic               prod_v_reg;
    logic [QW-1:0]      quo_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic               vis_reg;
    logic signed [31:0] sx_reg, sy_reg;

    logic [3:0]         m_idx;
    logic signed [31:0] pos_sel;
    logic signed [63:0] mul;
    logic signed [ACC_W-1:0] acc_add;
    logic signed [31:0] acc_sat;
    logic               vis_now;
    logic signed [31:0] num_sel;
    logic [31:0]        num_mag;
    logic [33:0]        rem_sh;
    logic [33:0]        rem_sub;
    logic signed [NDC_W-1:0] ndc;
    logic signed [DIM_W:0]   half_s;
    logic signed [PROD_W-1:0] scaled;
    logic signed [PROD_W-1:0] offset;
    logic signed [PROD_W:0]   total;
    logic signed [31:0]       total_sat;

    assign m_idx = {cmd.term, (cmd.row == 2'd2) ? 2'd3 : cmd.row};

    always_comb begin
        unique case (cmd.term)
            2'd0: pos_sel = px_reg;
            2'd1: pos_sel = py_reg;
            default: pos_sel = pz_reg;
        endcase
    end

    assign mul = pos_sel * mat_reg[m_idx];
    // floor shift of the product, or the translation entry as is
    assign acc_add = (cmd.term == 2'd3) ? ACC_W'(mat_reg[m_idx])
                                        : ACC_W'(prod_reg >>> FRAC_BITS);

    always_comb begin
        if (acc_reg > ACC_W'(64'sd2147483647))       acc_sat = 32'sh7fffffff;
        else if (acc_reg < ACC_W'(-64'sd2147483648)) acc_sat = 32'sh80000000;
        else                                         acc_sat = acc_reg[31:0];
    end

    // threshold test on the w sum while it is being clipped
    assign vis_now = (34'(acc_sat) >= THRESH);

    assign num_sel = cmd.axis ? cy_reg : cx_reg;
    assign num_mag = num_sel[31] ? 32'(-num_sel) : num_sel;
    assign rem_sh  = {rem_reg, quo_reg[QW-1]};
    assign rem_sub = rem_sh - {2'b00, den_reg};

    assign ndc    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign half_s = $signed({1'b0, cmd.axis ? half_h : half_w});
    assign scaled = cmd.axis ? PROD_W'(-(half_s * ndc)) : PROD_W'(half_s * ndc);
    assign offset = PROD_W'(half_s) <<< FRAC_BITS;
    assign total  = (PROD_W+1)'(scaled) + (PROD_W+1)'(offset);

    always_comb begin
        if (total > (PROD_W+1)'(64'sd2147483647))       total_sat = 32'sh7fffffff;
        else if (total < (PROD_W+1)'(-64'sd2147483648)) total_sat = 32'sh80000000;
        else                                            total_sat = total[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
            done_reg   <= 1'b0;
            vis_reg    <= 1'b0;
            prod_v_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            unique case (cmd.op)
                OP_IDLE: begin
                    px_reg <= in_x;
                    py_reg <= in_y;
                    pz_reg <= in_z;
                    acc_reg <= '0;
                    done_reg <= 1'b0;
                end
                OP_LOAD: mat_reg[load_index] <= load_value;
                OP_MAC: begin
                    // product registered first, added on the next beat
                    if (!prod_v_reg) begin
                        prod_reg   <= mul;
                        prod_v_reg <= (cmd.term != 2'd3);
                        if (cmd.term == 2'd3) acc_reg <= acc_reg + acc_add;
                    end else begin
                        acc_reg    <= acc_reg + acc_add;
                        prod_v_reg <= 1'b0;
                    end
                end
                OP_CLIP: begin
                    unique case (cmd.row)
                        2'd0:    cx_reg <= acc_sat;
                        2'd1:    cy_reg <= acc_sat;
                        default: begin
                            cw_reg  <= acc_sat;
                            vis_reg <= vis_now;
                        end
                    endcase
                    acc_reg <= '0;
                end
                OP_DIV_START: begin
                    quo_reg  <= QW'({num_mag, FRAC_BITS'(0)});
                    rem_reg  <= '0;
                    den_reg  <= cw_reg;
                    neg_reg  <= num_sel[31];
                    cnt_reg  <= CNT_W'(QW);
                    done_reg <= 1'b0;
                end
                OP_DIV_STEP: begin
                    // the controller leaves in the cycle after the last bit
                    if (cnt_reg != '0) begin
                        if (!rem_sub[33]) begin
                            rem_reg <= rem_sub[32:0];
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh[32:0];
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        cnt_reg  <= cnt_reg - 1'b1;
                        done_reg <= (cnt_reg == CNT_W'(1));
                    end
                end
                OP_SCALE: begin
                    if (cmd.axis) sy_reg <= total_sat;
                    else          sx_reg <= total_sat;
                    done_reg <= 1'b0;
                end
                OP_FINISH: begin
                    res_visible <= vis_reg;
                    res_x <= vis_reg ? sx_reg : '0;
                    res_y <= vis_reg ? sy_reg : '0;
                end
                default: ;
            endcase
        end
    end

    assign status.div_done = done_reg;
    assign status.visible  = vis_now;
endmodule

// ===== rtl/core/w2s_ctrl.sv =====
module w2s_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    output logic                 m_valid,
    input  logic                 m_ready,
    output w2s_pkg::w2s_cmd_t    cmd,
    input  w2s_pkg::w2s_status_t status
);
    import w2s_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAC, ST_CLIP, ST_DSTART, ST_DIV, ST_SCALE, ST_FIN, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] row_reg, term_reg;
    logic       axis_reg, half_reg, m_valid_reg;

    logic accept;
    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.row  = row_reg;
        cmd.term = term_reg;
        cmd.axis = axis_reg;
        unique case (state_reg)
            ST_IDLE:   cmd.op = (accept && s_command == CMD_LOAD) ? OP_LOAD : OP_IDLE;
            ST_MAC:    cmd.op = OP_MAC;
            ST_CLIP:   cmd.op = OP_CLIP;
            ST_DSTART: cmd.op = OP_DIV_START;
            ST_DIV:    cmd.op = OP_DIV_STEP;
            ST_SCALE:  cmd.op = OP_SCALE;
            ST_FIN:    cmd.op = OP_FINISH;
            default:   cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            term_reg    <= '0;
            axis_reg    <= 1'b0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (accept && s_command == CMD_PROJECT) begin
                    state_reg <= ST_MAC;
                    row_reg   <= '0;
                    term_reg  <= '0;
                    half_reg  <= 1'b0;
                end
                ST_MAC: begin
                    // each product term is multiplied, then added; translation is added directly
                    if (term_reg == 2'd3) state_reg <= ST_CLIP;
                    else if (half_reg) term_reg <= term_reg + 1'b1;
                    half_reg <= !half_reg && term_reg != 2'd3;
                end
                ST_CLIP: begin
                    term_reg <= '0;
                    half_reg <= 1'b0;
                    if (row_reg == 2'd2) begin
                        axis_reg  <= 1'b0;
                        state_reg <= status.visible ? ST_DSTART : ST_FIN;
                    end else begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_MAC;
                    end
                end
                ST_DSTART: state_reg <= ST_DIV;
                ST_DIV:    if (status.div_done) state_reg <= ST_SCALE;
                ST_SCALE: begin
                    if (axis_reg) state_reg <= ST_FIN;
                    else begin
                        axis_reg  <= 1'b1;
                        state_reg <= ST_DSTART;
                    end
                end
                ST_FIN: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: if (m_valid_reg && m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/world_to_screen_projection.sv =====
// world to screen projection
// input channel (s_valid/s_ready): a beat with s_command low loads matrix entry
// s_entry_index (column-major) from s_entry_value and gives no result; a beat
// with s_command high projects the point s_pos_x/y/z
// result channel (m_valid/m_ready): one beat per project with m_visible and
// saturated Q16.16 screen coordinates, zero when not visible
// config port: cfg_we writes cfg_index 0 (width) or 1 (height) at once
// one item is worked at a time; a load is written when it is accepted;
// a project sums clip x, y, w on one shared multiplier (each product term
// multiplied, then added, and a clip step per row); if visible, a restoring
// divider gives one quotient bit per cycle, 49 bits for ndc x and 49 for ndc y
// with a setup step before and a scaling step after per axis
// the next item is taken from the cycle after the result beat is taken; while
// the receiver stalls, the result holds and the input waits
// reset clears the matrix to zero and sets width 1920 and height 1080
module world_to_screen_projection #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_D
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [3:0]                  s_entry_index,
    input  logic signed [31:0]          s_entry_value,
    input  logic signed [31:0]          s_pos_x,
    input  logic signed [31:0]          s_pos_y,
    input  logic signed [31:0]          s_pos_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_visible,
    output logic signed [31:0]          m_screen_x,
    output logic signed [31:0]          m_screen_y,
    input  logic                        cfg_we,
    input  logic [w2s_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [w2s_pkg::DIM_W-1:0]   cfg_data
);
    import w2s_pkg::*;
    `include "world_to_screen_projection_macros.svh"

    logic [DIM_W-1:0] width_reg, height_reg;
    w2s_cmd_t    cmd;
    w2s_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    w2s_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command,
        .m_valid, .m_ready, .cmd, .status
    );

    w2s_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .status,
        .load_index(s_entry_index), .load_value(s_entry_value),
        .in_x(s_pos_x), .in_y(s_pos_y), .in_z(s_pos_z),
        .half_w(width_reg >> 1), .half_h(height_reg >> 1),
        .res_visible(m_visible), .res_x(m_screen_x), .res_y(m_screen_y)
    );

    `W2S_ASSERT_IMPL(a_no_ready_while_out, m_valid, !s_ready, "input taken while result pending")
    `W2S_ASSERT_NEXT(a_hold_while_stalled, m_valid && !m_ready, m_valid && $stable(m_visible) && $stable(m_screen_x) && $stable(m_screen_y), "result changed while stalled")
    `W2S_ASSERT_IMPL(a_hidden_coords, m_valid && !m_visible,
        m_screen_x == 32'sd0 && m_screen_y == 32'sd0, "hidden point with nonzero coords")
endmodule
